// File: sv/mp1d_pkg.sv
// shared types, constants and float helpers for the 1-d max pooling stream
// no dependencies
package mp1d_pkg;

  localparam int NUM_CELLS  = 64;
  localparam int IDX_W      = $clog2(NUM_CELLS);
  localparam int MAX_KERNEL = 16;
  localparam int RESULT_CAP = 64;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);
  localparam int D_W        = 18;
  // tap offsets reach (MAX_KERNEL-1) times the largest 5-bit dilation
  localparam int OFF_W      = 9;
  localparam int ADDR_W     = 5;

  // register indexes
  localparam logic [2:0] REG_KERNEL   = 3'd0;
  localparam logic [2:0] REG_STRIDE   = 3'd1;
  localparam logic [2:0] REG_PADDING  = 3'd2;
  localparam logic [2:0] REG_DILATION = 3'd3;
  localparam logic [2:0] REG_OUT_W    = 3'd4;
  localparam logic [2:0] REG_FORMAT   = 3'd5;

  typedef enum logic {ST_RUN, ST_FLUSH} mp1d_state_t;

  typedef struct packed {
    logic [4:0]  kernel_width;
    logic [4:0]  stride;
    logic [3:0]  padding;
    logic [4:0]  dilation;
    logic [15:0] output_width;
    logic        number_format;
  } cfg_t;

  // one open window
  typedef struct packed {
    logic [15:0]           max_v;
    logic                  valid;
    logic                  done;
    logic signed [D_W-1:0] d;
  } cell_state_t;

  // broadcast to every cell
  typedef struct packed {
    logic                                absorb;
    logic                                inc;
    logic                                fresh;
    logic                                fmt;
    logic [15:0]                         sample;
    logic [15:0]                         base;
    logic [15:0]                         ow;
    logic [3:0]                          pd;
    logic [4:0]                          st;
    logic [MAX_KERNEL-1:0]               tap_en;
    logic [MAX_KERNEL-1:0][OFF_W-1:0]    tap_off;
    logic [OFF_W-1:0]                    last_off;
  } cell_ctrl_t;

  function automatic logic [15:0] neg_inf(input logic fmt);
    return fmt ? 16'hFF80 : 16'hFC00;
  endfunction

  function automatic logic is_nan(input logic [15:0] v, input logic fmt);
    if (fmt) return (v[14:7] == 8'hFF) && (v[6:0] != 7'd0);
    return (v[14:10] == 5'h1F) && (v[9:0] != 10'd0);
  endfunction

  // order key for non-nan values, both zeros equal
  function automatic logic [15:0] order_key(input logic [15:0] v);
    if (v[14:0] == 15'd0) return 16'h8000;
    if (v[15]) return ~v;
    return v | 16'h8000;
  endfunction

  function automatic logic take_new(input logic [15:0] h, input logic [15:0] s,
                                    input logic fmt);
    return is_nan(s, fmt) || (!is_nan(h, fmt) && (order_key(h) < order_key(s)));
  endfunction

endpackage

// File: sv/mp1d_cfg.sv
// apb register file for the pooling settings
// depends on mp1d_pkg
module mp1d_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mp1d_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output mp1d_pkg::cfg_t              cfg
);
  import mp1d_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kernel_width  <= 5'd2;
      cfg_r.stride        <= 5'd2;
      cfg_r.padding       <= 4'd0;
      cfg_r.dilation      <= 5'd1;
      cfg_r.output_width  <= 16'd1;
      cfg_r.number_format <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_KERNEL:   cfg_r.kernel_width  <= pwdata[4:0];
        REG_STRIDE:   cfg_r.stride        <= pwdata[4:0];
        REG_PADDING:  cfg_r.padding       <= pwdata[3:0];
        REG_DILATION: cfg_r.dilation      <= pwdata[4:0];
        REG_OUT_W:    cfg_r.output_width  <= pwdata[15:0];
        REG_FORMAT:   cfg_r.number_format <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_KERNEL:   prdata = {27'd0, cfg_r.kernel_width};
      REG_STRIDE:   prdata = {27'd0, cfg_r.stride};
      REG_PADDING:  prdata = {28'd0, cfg_r.padding};
      REG_DILATION: prdata = {27'd0, cfg_r.dilation};
      REG_OUT_W:    prdata = {16'd0, cfg_r.output_width};
      REG_FORMAT:   prdata = {31'd0, cfg_r.number_format};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// File: sv/mp1d_cell.sv
// one open pooling window: running max, distance to its first tap, done flag
// depends on mp1d_pkg
module mp1d_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mp1d_pkg::IDX_W-1:0] cell_idx,
  input  mp1d_pkg::cell_ctrl_t       ctrl,
  input  logic                       upd,
  input  logic                       shift,
  input  mp1d_pkg::cell_state_t      nb_nxt,
  output mp1d_pkg::cell_state_t      eff,
  output mp1d_pkg::cell_state_t      nxt,
  output logic                       live
);
  import mp1d_pkg::*;

  cell_state_t     state_r;
  logic [10:0]     prod;
  logic [D_W-1:0]  init_d;
  logic            reach;
  logic            hit;
  logic [15:0]     held;

  // distance at row start: padding minus own window start
  assign prod   = {5'd0, cell_idx} * {6'd0, ctrl.st};
  assign init_d = D_W'(ctrl.pd) - D_W'(prod);

  always_comb begin
    if (ctrl.fresh) begin
      eff.max_v = neg_inf(ctrl.fmt);
      eff.valid = 1'b0;
      eff.done  = 1'b0;
      eff.d     = $signed(init_d);
    end else begin
      eff = state_r;
    end
  end

  assign live  = ({1'b0, ctrl.base} + 17'(cell_idx)) < {1'b0, ctrl.ow};
  assign reach = ctrl.absorb && live && !eff.d[D_W-1];
  assign held  = eff.valid ? eff.max_v : neg_inf(ctrl.fmt);

  // tap match against the precomputed offsets
  always_comb begin
    hit = 1'b0;
    for (int t = 0; t < MAX_KERNEL; t++) begin
      if (ctrl.tap_en[t] && (eff.d[D_W-2:OFF_W] == '0) && (eff.d[OFF_W-1:0] == ctrl.tap_off[t]))
        hit = 1'b1;
    end
  end

  // absorbed state for this beat
  always_comb begin
    nxt.max_v = reach ? ((hit && take_new(held, ctrl.sample, ctrl.fmt)) ? ctrl.sample : held)
                      : eff.max_v;
    nxt.valid = eff.valid | reach;
    nxt.done  = eff.done | (ctrl.absorb && !eff.d[D_W-1] &&
                            (eff.d[D_W-2:0] >= (D_W-1)'(ctrl.last_off)));
    nxt.d     = (ctrl.absorb && ctrl.inc) ? eff.d + 18'sd1 : eff.d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.valid <= 1'b0;
      state_r.done  <= 1'b0;
    end else if (upd) begin
      state_r.valid <= shift ? nb_nxt.valid : nxt.valid;
      state_r.done  <= shift ? nb_nxt.done : nxt.done;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      state_r.max_v <= shift ? nb_nxt.max_v : nxt.max_v;
      state_r.d     <= shift ? nb_nxt.d : nxt.d;
    end
  end

endmodule

// File: sv/max_pool_1d_stream.sv
// top level of the 1-d max pooling stream: register file, row of window cells
// depends on mp1d_pkg, mp1d_cfg, mp1d_cell
//
// Takes one 16-bit float sample (half or bfloat16) per beat and keeps up to 64
// open windows in a row of cells that all see the sample in the same cycle;
// the oldest window sits in the first cell and the row shifts by one as it is
// emitted. Steady state is one sample per cycle with one result per cycle. A
// sample beat is held off while the output is stalled with a finished window
// waiting, while two finished windows are queued, or during a row-end flush,
// which emits the remaining windows (at most 64) and then restarts the row.
module max_pool_1d_stream (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [15:0]                 in_sample,
  input  logic                        in_row_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [15:0]                 out_max_value,
  output logic                        out_run_last,
  output logic                        out_row_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mp1d_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import mp1d_pkg::*;

  cfg_t         cfg;
  cell_ctrl_t   ctrl;
  mp1d_state_t  state_r, state_nxt;
  cell_state_t  eff  [NUM_CELLS];
  cell_state_t  nxt  [NUM_CELLS];
  logic         live [NUM_CELLS];
  cell_state_t  tail;

  logic [4:0]       k_eff, st_eff, dl_eff;
  logic [15:0]      ow_eff;
  logic [15:0]      base_r, pos_r;
  logic             fresh_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r, run_last_r, row_last_r;
  logic [15:0]      max_r;

  logic pend0, pend1, out_free, emit, last_res, accept, row_done, upd;

  mp1d_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // effective settings
  always_comb begin
    k_eff  = (cfg.kernel_width == 5'd0) ? 5'd1 :
             (cfg.kernel_width > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : cfg.kernel_width;
    st_eff = (cfg.stride == 5'd0) ? 5'd1 : cfg.stride;
    dl_eff = (cfg.dilation == 5'd0) ? 5'd1 : cfg.dilation;
    ow_eff = (cfg.output_width == 16'd0) ? 16'd1 : cfg.output_width;
  end

  // broadcast to the cells
  always_comb begin
    ctrl.absorb   = accept;
    ctrl.inc      = (pos_r != 16'hFFFF);
    ctrl.fresh    = fresh_r;
    ctrl.fmt      = cfg.number_format;
    ctrl.sample   = in_sample;
    ctrl.base     = base_r;
    ctrl.ow       = ow_eff;
    ctrl.pd       = cfg.padding;
    ctrl.st       = st_eff;
    ctrl.last_off = OFF_W'(({5'd0, k_eff} - 10'd1) * {5'd0, dl_eff});
    for (int t = 0; t < MAX_KERNEL; t++) begin
      ctrl.tap_en[t]  = (t < int'(k_eff));
      ctrl.tap_off[t] = OFF_W'(t * int'(dl_eff));
    end
  end

  // fresh window entering at the end of the row
  always_comb begin
    tail.max_v = neg_inf(cfg.number_format);
    tail.valid = 1'b0;
    tail.done  = 1'b0;
    tail.d     = nxt[NUM_CELLS-1].d - $signed({{(D_W-5){1'b0}}, st_eff});
  end

  // row of window cells
  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    cell_state_t nb;
    if (j == NUM_CELLS - 1) begin : g_tail
      assign nb = tail;
    end else begin : g_mid
      assign nb = nxt[j+1];
    end
    mp1d_cell u_cell (
      .clk, .rst_n,
      .cell_idx (IDX_W'(j)),
      .ctrl,
      .upd,
      .shift    (emit),
      .nb_nxt   (nb),
      .eff      (eff[j]),
      .nxt      (nxt[j]),
      .live     (live[j])
    );
  end

  // emission and handshake control
  always_comb begin
    pend0     = live[0] && eff[0].done;
    pend1     = live[1] && eff[1].done;
    out_free  = !out_valid_r || !out_stall;
    state_nxt = state_r;
    emit      = 1'b0;
    last_res  = 1'b0;
    row_done  = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        emit     = pend0 && out_free;
        last_res = !pend1;
        if (accept && in_row_end) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        emit     = live[0] && (cnt_r < CNT_W'(RESULT_CAP)) && out_free;
        last_res = !live[1] || (cnt_r == CNT_W'(RESULT_CAP - 1));
        row_done = !(live[0] && (cnt_r < CNT_W'(RESULT_CAP)));
        if (row_done) state_nxt = ST_RUN;
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  assign in_stall = !((state_r == ST_RUN) && (!pend0 || (emit && !pend1)));
  assign accept   = in_valid && !in_stall;
  assign upd      = accept || emit;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_RUN;
    else        state_r <= state_nxt;
  end

  // row position, output index, flush count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= 16'd0;
      pos_r   <= 16'd0;
      fresh_r <= 1'b1;
      cnt_r   <= '0;
    end else begin
      if (row_done) begin
        base_r  <= 16'd0;
        pos_r   <= 16'd0;
        fresh_r <= 1'b1;
      end else begin
        if (emit) base_r <= base_r + 16'd1;
        if (accept) begin
          fresh_r <= 1'b0;
          if (pos_r != 16'hFFFF) pos_r <= pos_r + 16'd1;
        end
      end
      if (accept && in_row_end) cnt_r <= '0;
      else if (emit && (state_r == ST_FLUSH)) cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      max_r      <= eff[0].valid ? eff[0].max_v : neg_inf(cfg.number_format);
      run_last_r <= last_res;
      row_last_r <= last_res && (state_r == ST_FLUSH);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_max_value = max_r;
  assign out_run_last  = run_last_r;
  assign out_row_last  = row_last_r;

  // checks
  a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> in_stall) else $error("input taken during flush");

  a_row_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_row_end) |=> (state_r == ST_FLUSH)) else $error("row end not flushed");

  a_run_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (state_r == ST_RUN)) |-> (eff[0].done && live[0]))
    else $error("unfinished window emitted");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RESULT_CAP)) else $error("flush count overrun");

endmodule
